### sv/pdbr_pkg.sv
// Shared types and constants of the PPG detrend / bandpass / RMS block.
// Holds the controller-to-datapath command codes, the command and status
// structs, and the fixed Q2.30 biquad coefficients. No dependencies.
package pdbr_pkg;

    localparam int OP_W = 5;

    localparam logic [OP_W-1:0] OP_NONE = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
    localparam logic [OP_W-1:0] OP_RD   = 5'd2;
    localparam logic [OP_W-1:0] OP_WIN  = 5'd3;
    localparam logic [OP_W-1:0] OP_BDIV = 5'd4;
    localparam logic [OP_W-1:0] OP_BASE = 5'd5;
    localparam logic [OP_W-1:0] OP_M_B0 = 5'd6;
    localparam logic [OP_W-1:0] OP_Y    = 5'd7;
    localparam logic [OP_W-1:0] OP_M_A1 = 5'd8;
    localparam logic [OP_W-1:0] OP_D0   = 5'd9;
    localparam logic [OP_W-1:0] OP_M_A2 = 5'd10;
    localparam logic [OP_W-1:0] OP_D1   = 5'd11;
    localparam logic [OP_W-1:0] OP_SMW  = 5'd12;
    localparam logic [OP_W-1:0] OP_SDIV = 5'd13;
    localparam logic [OP_W-1:0] OP_F    = 5'd14;
    localparam logic [OP_W-1:0] OP_ACC  = 5'd15;
    localparam logic [OP_W-1:0] OP_RDIV = 5'd16;
    localparam logic [OP_W-1:0] OP_SQRT = 5'd17;
    localparam logic [OP_W-1:0] OP_RMS  = 5'd18;

    // Q2.30 coefficients; b1 is zero and b2 is -b0 in both sections
    localparam logic signed [31:0] S1_B0 = 32'sd7987737;
    localparam logic signed [31:0] S1_A1 = -32'sd2000585781;
    localparam logic signed [31:0] S1_A2 = 32'sd938877499;
    localparam logic signed [31:0] S2_B0 = 32'sd1073741824;
    localparam logic signed [31:0] S2_A1 = -32'sd2089848709;
    localparam logic signed [31:0] S2_A2 = 32'sd1021391692;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sec;
    } pdbr_cmd_t;

    typedef struct packed {
        logic busy;
        logic cnt_zero;
    } pdbr_stat_t;

endpackage

### sv/pdbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdbr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pdbr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// The dividend arrives left-aligned with n_bits significant bits. No dependencies.
module pdbr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    input  logic [6:0]  n_bits,
    output logic        busy,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] dq_reg, dq_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dq_reg[63]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = n_bits;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : rem_sh[31:0];
            dq_next  = {dq_reg[62:0], ge};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

### sv/pdbr_ctrl.sv
// Controller of the PPG detrend / bandpass / RMS block: sequences the
// datapath one transaction at a time and owns the handshakes. Uses pdbr_pkg.
module pdbr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  pdbr_pkg::pdbr_stat_t stat,
    output pdbr_pkg::pdbr_cmd_t  ctl
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_WIN  = 5'd2;
    localparam logic [4:0] S_BDIV = 5'd3;
    localparam logic [4:0] S_BASE = 5'd4;
    localparam logic [4:0] S_MB0  = 5'd5;
    localparam logic [4:0] S_Y    = 5'd6;
    localparam logic [4:0] S_MA1  = 5'd7;
    localparam logic [4:0] S_D0   = 5'd8;
    localparam logic [4:0] S_MA2  = 5'd9;
    localparam logic [4:0] S_D1   = 5'd10;
    localparam logic [4:0] S_SMW  = 5'd11;
    localparam logic [4:0] S_SDIV = 5'd12;
    localparam logic [4:0] S_F    = 5'd13;
    localparam logic [4:0] S_ACC  = 5'd14;
    localparam logic [4:0] S_RDIV = 5'd15;
    localparam logic [4:0] S_SQRT = 5'd16;
    localparam logic [4:0] S_RMS  = 5'd17;
    localparam logic [4:0] S_WAIT = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       sec_reg, sec_next;
    logic       out_valid_reg, out_valid_next;
    logic [pdbr_pkg::OP_W-1:0] op;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        sec_next   = sec_reg;
        op         = pdbr_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op       = pdbr_pkg::OP_LOAD;
                    sec_next = 1'b0;
                    if (!cmd)
                    begin
                        state_next = S_RD;
                    end
                    else if (stat.cnt_zero)
                    begin
                        state_next = S_RMS;
                    end
                    else
                    begin
                        state_next = S_RDIV;
                    end
                end
            end
            S_RD:
            begin
                op         = pdbr_pkg::OP_RD;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                op         = pdbr_pkg::OP_WIN;
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                op         = pdbr_pkg::OP_BDIV;
                state_next = S_WAIT;
                ret_next   = S_BASE;
            end
            S_BASE:
            begin
                op         = pdbr_pkg::OP_BASE;
                state_next = S_MB0;
            end
            S_MB0:
            begin
                op         = pdbr_pkg::OP_M_B0;
                state_next = S_WAIT;
                ret_next   = S_Y;
            end
            S_Y:
            begin
                op         = pdbr_pkg::OP_Y;
                state_next = S_MA1;
            end
            S_MA1:
            begin
                op         = pdbr_pkg::OP_M_A1;
                state_next = S_WAIT;
                ret_next   = S_D0;
            end
            S_D0:
            begin
                op         = pdbr_pkg::OP_D0;
                state_next = S_MA2;
            end
            S_MA2:
            begin
                op         = pdbr_pkg::OP_M_A2;
                state_next = S_WAIT;
                ret_next   = S_D1;
            end
            S_D1:
            begin
                op = pdbr_pkg::OP_D1;
                if (sec_reg)
                begin
                    state_next = S_SMW;
                end
                else
                begin
                    sec_next   = 1'b1;
                    state_next = S_MB0;
                end
            end
            S_SMW:
            begin
                op         = pdbr_pkg::OP_SMW;
                state_next = S_SDIV;
            end
            S_SDIV:
            begin
                op         = pdbr_pkg::OP_SDIV;
                state_next = S_WAIT;
                ret_next   = S_F;
            end
            S_F:
            begin
                op         = pdbr_pkg::OP_F;
                state_next = S_WAIT;
                ret_next   = S_ACC;
            end
            S_ACC:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    op         = pdbr_pkg::OP_ACC;
                    state_next = S_IDLE;
                end
            end
            S_RDIV:
            begin
                op         = pdbr_pkg::OP_RDIV;
                state_next = S_WAIT;
                ret_next   = S_SQRT;
            end
            S_SQRT:
            begin
                op         = pdbr_pkg::OP_SQRT;
                state_next = S_WAIT;
                ret_next   = S_RMS;
            end
            S_RMS:
            begin
                if (out_free)
                begin
                    op         = pdbr_pkg::OP_RMS;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (op == pdbr_pkg::OP_ACC || op == pdbr_pkg::OP_RMS)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            sec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign ctl.op    = op;
    assign ctl.sec   = sec_reg;

endmodule

### sv/pdbr_dp.sv
// Datapath of the PPG detrend / bandpass / RMS block: window store, shared
// multiplier, divider and square root, filter state and output registers.
// Uses pdbr_pkg, pdbr_ram and pdbr_div.
module pdbr_dp #(
    parameter int WINDOW_LEN  = 64,
    parameter int SMOOTH_TAPS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdbr_pkg::pdbr_cmd_t  ctl,
    output pdbr_pkg::pdbr_stat_t stat,
    input  logic [17:0]          raw_sample,
    output logic signed [31:0]   filtered_value,
    output logic [25:0]          dc_level,
    output logic [25:0]          ac_rms,
    output logic                 rms_empty
);

    localparam int PW  = $clog2(WINDOW_LEN);
    localparam int CW  = $clog2(WINDOW_LEN + 1);
    localparam int SW  = 18 + PW;
    localparam int TW  = $clog2(SMOOTH_TAPS);
    localparam int SMW = 41 + TW;
    localparam int VW  = 54;
    localparam int SRW = 96;
    localparam int SSH = SMW + TW;
    // reciprocal of the tap count, rounded up: exact for magnitudes below 2^SMW
    localparam logic [47:0] SRECIP =
        48'(((64'd1 << SSH) + 64'(SMOOTH_TAPS) - 64'd1) / 64'(SMOOTH_TAPS));

    function automatic logic signed [39:0] sat40(input logic signed [VW-1:0] v);
        if (v[VW-1:39] == {(VW-39){v[VW-1]}})
        begin
            return v[39:0];
        end
        return v[VW-1] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [VW-1:0] v);
        if (v[VW-1:47] == {(VW-47){v[VW-1]}})
        begin
            return v[47:0];
        end
        return v[VW-1] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    endfunction

    // window state
    logic [17:0]          raw_reg, raw_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic                 full_reg, full_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [25:0]          base_reg, base_next;
    // filter state
    logic signed [39:0]   x_reg, x_next;
    logic signed [39:0]   y_reg, y_next;
    logic signed [VW-1:0] bx_reg, bx_next;
    logic signed [47:0]   d0_reg [2];
    logic signed [47:0]   d0_next [2];
    logic signed [47:0]   d1_reg [2];
    logic signed [47:0]   d1_next [2];
    logic signed [39:0]   sm_reg [SMOOTH_TAPS];
    logic signed [39:0]   sm_next [SMOOTH_TAPS];
    logic [TW-1:0]        sp_reg, sp_next;
    logic                 sneg_reg, sneg_next;
    logic signed [31:0]   f_reg, f_next;
    logic [63:0]          acc_reg, acc_next;
    logic [31:0]          sqc_reg, sqc_next;
    // multiplier
    logic [47:0]          mm_reg, mm_next;
    logic [31:0]          mk_reg, mk_next;
    logic                 mneg_reg, mneg_next;
    logic [79:0]          macc_reg, macc_next;
    logic [1:0]           mcnt_reg, mcnt_next;
    logic                 mbusy_reg, mbusy_next;
    // smoothing mean by reciprocal multiply
    logic [47:0]          sn_reg, sn_next;
    logic [SRW-1:0]       sacc_reg, sacc_next;
    logic [2:0]           scnt_reg, scnt_next;
    logic                 sbusy_reg, sbusy_next;
    // square root
    logic [63:0]          qv_reg, qv_next;
    logic [33:0]          qrem_reg, qrem_next;
    logic [31:0]          qroot_reg, qroot_next;
    logic [4:0]           qcnt_reg, qcnt_next;
    logic                 qbusy_reg, qbusy_next;
    // output registers
    logic signed [31:0]   of_reg, of_next;
    logic [25:0]          odc_reg, odc_next;
    logic [25:0]          orms_reg, orms_next;
    logic                 oempty_reg, oempty_next;

    logic [17:0]          ram_rdata;
    logic                 div_start;
    logic [63:0]          div_dividend;
    logic [31:0]          div_divisor;
    logic [6:0]           div_n;
    logic                 div_busy;
    logic [63:0]          div_q;

    logic signed [SMW-1:0] ssum;
    logic [SMW-1:0]        smag;
    logic [SRW-1:0]        squo;
    logic [79:0]           mround;
    logic [VW-1:0]         mres_u;
    logic signed [VW-1:0]  mres;
    logic signed [39:0]    ma;
    logic signed [31:0]    mc;
    logic signed [31:0]    b0_c, a1_c, a2_c;
    logic signed [SMW:0]   s_val;
    logic signed [SMW:0]   s_rnd;
    logic signed [31:0]    f_c;
    logic [31:0]           f_abs;
    logic [64:0]           acc_sum;
    logic [34:0]           q_sh;
    logic [34:0]           q_trial;
    logic                  q_ge;
    logic                  last_pos;
    logic                  mul_go;

    pdbr_ram #(
        .WIDTH(18),
        .DEPTH(WINDOW_LEN)
    ) u_win (
        .clk   (clk),
        .we    (ctl.op == pdbr_pkg::OP_WIN),
        .waddr (pos_reg),
        .wdata (raw_reg),
        .re    (ctl.op == pdbr_pkg::OP_RD),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    pdbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .n_bits   (div_n),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        b0_c = ctl.sec ? pdbr_pkg::S2_B0 : pdbr_pkg::S1_B0;
        a1_c = ctl.sec ? pdbr_pkg::S2_A1 : pdbr_pkg::S1_A1;
        a2_c = ctl.sec ? pdbr_pkg::S2_A2 : pdbr_pkg::S1_A2;

        ssum = '0;
        for (int i = 0; i < SMOOTH_TAPS; i++)
        begin
            ssum = ssum + SMW'(sm_reg[i]);
        end
        smag = ssum[SMW-1] ? SMW'(-ssum) : SMW'(ssum);
        squo = sacc_reg >> SSH;

        // round to nearest, ties away from zero, on the magnitude
        mround = macc_reg + (80'd1 << 29);
        mres_u = {{(VW-50){1'b0}}, mround[79:30]};
        mres   = mneg_reg ? -$signed(mres_u) : $signed(mres_u);

        s_val = sneg_reg ? -$signed({1'b0, squo[SMW-1:0]})
                         : $signed({1'b0, squo[SMW-1:0]});
        s_rnd = (s_val + (SMW+1)'(128)) >>> 8;
        if (s_rnd[SMW:31] == {(SMW-30){s_rnd[SMW]}})
        begin
            f_c = s_rnd[31:0];
        end
        else
        begin
            f_c = s_rnd[SMW] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        f_abs = f_c[31] ? 32'(-f_c) : 32'(f_c);

        acc_sum  = {1'b0, acc_reg} + {1'b0, macc_reg[63:0]};
        last_pos = (pos_reg == PW'(WINDOW_LEN - 1));

        q_sh    = {qrem_reg[32:0], qv_reg[63:62]};
        q_trial = {1'b0, qroot_reg, 2'b01};
        q_ge    = (q_sh >= q_trial);

        raw_next    = raw_reg;
        pos_next    = pos_reg;
        full_next   = full_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        bx_next     = bx_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        sm_next     = sm_reg;
        sp_next     = sp_reg;
        sneg_next   = sneg_reg;
        f_next      = f_reg;
        acc_next    = acc_reg;
        sqc_next    = sqc_reg;
        of_next     = of_reg;
        odc_next    = odc_reg;
        orms_next   = orms_reg;
        oempty_next = oempty_reg;

        div_start    = 1'b0;
        div_dividend = acc_reg;
        div_divisor  = sqc_reg;
        div_n        = 7'd64;

        mul_go = 1'b0;
        ma     = x_reg;
        mc     = b0_c;

        case (ctl.op)
            pdbr_pkg::OP_LOAD:
            begin
                raw_next = raw_sample;
            end
            pdbr_pkg::OP_WIN:
            begin
                sum_next = sum_reg - (full_reg ? SW'(ram_rdata) : SW'(0)) + SW'(raw_reg);
                if (last_pos)
                begin
                    pos_next  = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                end
                cnt_next = (full_reg || last_pos) ? CW'(WINDOW_LEN)
                                                  : CW'(pos_reg) + CW'(1);
            end
            pdbr_pkg::OP_BDIV:
            begin
                div_start    = 1'b1;
                div_dividend = {sum_reg, 8'b0, {(56-SW){1'b0}}};
                div_divisor  = 32'(cnt_reg);
                div_n        = 7'(SW + 8);
            end
            pdbr_pkg::OP_BASE:
            begin
                base_next = div_q[25:0];
                x_next    = $signed({6'b0, raw_reg, 16'b0})
                          - $signed({6'b0, div_q[25:0], 8'b0});
            end
            pdbr_pkg::OP_M_B0:
            begin
                mul_go = 1'b1;
            end
            pdbr_pkg::OP_Y:
            begin
                bx_next = mres;
                y_next  = sat40(mres + VW'(d0_reg[ctl.sec]));
            end
            pdbr_pkg::OP_M_A1:
            begin
                mul_go = 1'b1;
                ma     = y_reg;
                mc     = a1_c;
            end
            pdbr_pkg::OP_D0:
            begin
                d0_next[ctl.sec] = sat48(VW'(d1_reg[ctl.sec]) - mres);
            end
            pdbr_pkg::OP_M_A2:
            begin
                mul_go = 1'b1;
                ma     = y_reg;
                mc     = a2_c;
            end
            pdbr_pkg::OP_D1:
            begin
                d1_next[ctl.sec] = sat48(-bx_reg - mres);
                x_next           = y_reg;
            end
            pdbr_pkg::OP_SMW:
            begin
                sm_next[sp_reg] = y_reg;
                sp_next = (sp_reg == TW'(SMOOTH_TAPS - 1)) ? '0 : sp_reg + TW'(1);
            end
            pdbr_pkg::OP_SDIV:
            begin
                // divide the magnitude, restore the sign after: truncates toward zero
                sneg_next = ssum[SMW-1];
            end
            pdbr_pkg::OP_F:
            begin
                f_next = f_c;
            end
            pdbr_pkg::OP_ACC:
            begin
                acc_next    = acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
                sqc_next    = (&sqc_reg) ? sqc_reg : sqc_reg + 32'd1;
                of_next     = f_reg;
                odc_next    = base_reg;
                orms_next   = '0;
                oempty_next = 1'b0;
            end
            pdbr_pkg::OP_RDIV:
            begin
                div_start = 1'b1;
            end
            pdbr_pkg::OP_RMS:
            begin
                of_next     = '0;
                odc_next    = base_reg;
                oempty_next = (sqc_reg == 32'd0);
                if (sqc_reg == 32'd0)
                begin
                    orms_next = '0;
                end
                else
                begin
                    orms_next = (|qroot_reg[31:26]) ? {26{1'b1}} : qroot_reg[25:0];
                end
                acc_next = '0;
                sqc_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // shared multiplier: 16 bits of the magnitude per cycle, top chunk first
    always_comb
    begin
        mm_next    = mm_reg;
        mk_next    = mk_reg;
        mneg_next  = mneg_reg;
        macc_next  = macc_reg;
        mcnt_next  = mcnt_reg;
        mbusy_next = mbusy_reg;
        if (mul_go)
        begin
            mm_next    = {8'b0, (ma[39] ? 40'(-ma) : 40'(ma))};
            mk_next    = mc[31] ? 32'(-mc) : 32'(mc);
            mneg_next  = ma[39] ^ mc[31];
            macc_next  = '0;
            mcnt_next  = 2'd3;
            mbusy_next = 1'b1;
        end
        else if (ctl.op == pdbr_pkg::OP_F)
        begin
            mm_next    = {16'b0, f_abs};
            mk_next    = f_abs;
            mneg_next  = 1'b0;
            macc_next  = '0;
            mcnt_next  = 2'd3;
            mbusy_next = 1'b1;
        end
        else if (mbusy_reg)
        begin
            macc_next = (macc_reg << 16) + 80'(mm_reg[47:32] * mk_reg);
            mm_next   = mm_reg << 16;
            mcnt_next = mcnt_reg - 2'd1;
            if (mcnt_reg == 2'd1)
            begin
                mbusy_next = 1'b0;
            end
        end
    end

    // smoothing mean: multiply the magnitude by the reciprocal, 8 bits per cycle
    always_comb
    begin
        sn_next    = sn_reg;
        sacc_next  = sacc_reg;
        scnt_next  = scnt_reg;
        sbusy_next = sbusy_reg;
        if (ctl.op == pdbr_pkg::OP_SDIV)
        begin
            sn_next    = 48'(smag);
            sacc_next  = '0;
            scnt_next  = 3'd6;
            sbusy_next = 1'b1;
        end
        else if (sbusy_reg)
        begin
            sacc_next = (sacc_reg << 8) + SRW'(sn_reg[47:40]) * SRW'(SRECIP);
            sn_next   = sn_reg << 8;
            scnt_next = scnt_reg - 3'd1;
            if (scnt_reg == 3'd1)
            begin
                sbusy_next = 1'b0;
            end
        end
    end

    // square root, two radicand bits per cycle
    always_comb
    begin
        qv_next    = qv_reg;
        qrem_next  = qrem_reg;
        qroot_next = qroot_reg;
        qcnt_next  = qcnt_reg;
        qbusy_next = qbusy_reg;
        if (ctl.op == pdbr_pkg::OP_SQRT)
        begin
            qv_next    = div_q;
            qrem_next  = '0;
            qroot_next = '0;
            qcnt_next  = 5'd31;
            qbusy_next = 1'b1;
        end
        else if (qbusy_reg)
        begin
            qrem_next  = q_ge ? 34'(q_sh - q_trial) : 34'(q_sh);
            qroot_next = {qroot_reg[30:0], q_ge};
            qv_next    = qv_reg << 2;
            qcnt_next  = qcnt_reg - 5'd1;
            if (qcnt_reg == 5'd0)
            begin
                qbusy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            sum_reg   <= '0;
            base_reg  <= '0;
            d0_reg    <= '{default: '0};
            d1_reg    <= '{default: '0};
            sm_reg    <= '{default: '0};
            sp_reg    <= '0;
            acc_reg   <= '0;
            sqc_reg   <= '0;
            mcnt_reg  <= '0;
            mbusy_reg <= 1'b0;
            scnt_reg  <= '0;
            sbusy_reg <= 1'b0;
            qcnt_reg  <= '0;
            qbusy_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            full_reg  <= full_next;
            sum_reg   <= sum_next;
            base_reg  <= base_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            sm_reg    <= sm_next;
            sp_reg    <= sp_next;
            acc_reg   <= acc_next;
            sqc_reg   <= sqc_next;
            mcnt_reg  <= mcnt_next;
            mbusy_reg <= mbusy_next;
            scnt_reg  <= scnt_next;
            sbusy_reg <= sbusy_next;
            qcnt_reg  <= qcnt_next;
            qbusy_reg <= qbusy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        bx_reg     <= bx_next;
        sneg_reg   <= sneg_next;
        f_reg      <= f_next;
        mm_reg     <= mm_next;
        mk_reg     <= mk_next;
        mneg_reg   <= mneg_next;
        macc_reg   <= macc_next;
        sn_reg     <= sn_next;
        sacc_reg   <= sacc_next;
        qv_reg     <= qv_next;
        qrem_reg   <= qrem_next;
        qroot_reg  <= qroot_next;
        of_reg     <= of_next;
        odc_reg    <= odc_next;
        orms_reg   <= orms_next;
        oempty_reg <= oempty_next;
    end

    assign stat.busy      = mbusy_reg | sbusy_reg | qbusy_reg | div_busy;
    assign stat.cnt_zero  = (sqc_reg == 32'd0);
    assign filtered_value = of_reg;
    assign dc_level       = odc_reg;
    assign ac_rms         = orms_reg;
    assign rms_empty      = oempty_reg;

endmodule

### sv/ppg_detrend_bandpass_rms_unit.sv
// PPG detrend, 0.5-4 Hz bandpass and AC RMS unit: top level.
// Joins pdbr_ctrl and pdbr_dp; uses pdbr_pkg.
//
// Input channel (in_valid / in_stall): cmd 0 carries a raw_sample to
// filter; cmd 1 reads the AC RMS accumulated since the last read and
// clears it. Each transaction returns one result on the output channel
// (out_valid / out_stall): filtered_value and dc_level for a sample,
// dc_level, ac_rms and rms_empty for a read.
// One transaction is worked at a time; in_stall is high from acceptance
// until its result is loaded into the output register. A sample runs the
// baseline divide (one bit per cycle over the window sum plus eight), six
// multiplies of the two biquads, the reciprocal multiply of the smoothing
// mean and the squaring. A read runs a 64-bit divide and a 32-bit square
// root, or skips both when nothing was accumulated.
// Reset clears the window sum and position, filter delays, smoothing
// taps and accumulators; the window memory needs no clearing pass.
// While the receiver stalls, the result is held and a finished next
// result waits in the controller until the output register frees up.
module ppg_detrend_bandpass_rms_unit #(
    parameter int WINDOW_LEN  = 64,
    parameter int SMOOTH_TAPS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [17:0]        raw_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] filtered_value,
    output logic [25:0]        dc_level,
    output logic [25:0]        ac_rms,
    output logic               rms_empty
);

    pdbr_pkg::pdbr_cmd_t  ctl;
    pdbr_pkg::pdbr_stat_t stat;

    pdbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    pdbr_dp #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SMOOTH_TAPS (SMOOTH_TAPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .raw_sample     (raw_sample),
        .filtered_value (filtered_value),
        .dc_level       (dc_level),
        .ac_rms         (ac_rms),
        .rms_empty      (rms_empty)
    );

endmodule

### tb/tb_ppg_detrend_bandpass_rms_unit.sv
// Self-checking testbench for ppg_detrend_bandpass_rms_unit.
// Drives a directed table and then random sample and read traffic,
// predicts each result in-bench and compares every field. Uses pdbr_pkg.
`timescale 1ns / 100ps

module tb_ppg_detrend_bandpass_rms_unit;

    localparam int WIN        = 64;
    localparam int TAPS       = 3;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_LEN   = 900;
    localparam int N_RANDOM   = 1500;
    localparam bit CMD_SAMPLE = 1'b0;
    localparam bit CMD_READ   = 1'b1;

    typedef struct packed {
        logic signed [31:0] fv;
        logic [25:0]        dc;
        logic [25:0]        rms;
        logic               empty;
    } result_t;

    typedef struct {
        bit          op;
        logic [17:0] raw;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               cmd = 1'b0;
    logic [17:0]        raw_sample = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] filtered_value;
    logic [25:0]        dc_level;
    logic [25:0]        ac_rms;
    logic               rms_empty;

    // predictor state
    logic [17:0]        win_mem [WIN];
    logic [63:0]        win_sum;
    int                 win_pos;
    bit                 win_full;
    logic signed [63:0] sec_dly [4];
    logic signed [63:0] smooth_mem [TAPS];
    int                 smooth_pos;
    logic [25:0]        baseline;
    logic [63:0]        sq_acc;
    logic [31:0]        sq_cnt;

    result_t pending_results[$];
    int      n_errors;
    int      n_samples;
    int      n_reads;
    int      n_checked;
    int      idle_cycles;
    bit      accepted_any;

    ppg_detrend_bandpass_rms_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .raw_sample(raw_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .filtered_value(filtered_value), .dc_level(dc_level),
        .ac_rms(ac_rms), .rms_empty(rms_empty)
    );

    always #2 clk = ~clk;

    function automatic logic signed [63:0] clamp(logic signed [63:0] v, int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // x * c / 2^30, rounded to nearest with ties away from zero
    function automatic logic signed [63:0] scale_q30(logic signed [63:0] x,
                                                     logic signed [31:0] c);
        logic         neg;
        logic [63:0]  m;
        logic [63:0]  k;
        logic [127:0] p;
        neg = (x < 0) != (c < 0);
        m = (x < 0) ? 64'(-x) : 64'(x);
        k = (c < 0) ? 64'(-64'(c)) : 64'(c);
        p = ({64'd0, m} * {64'd0, k} + (128'd1 << 29)) >> 30;
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] biquad_section(logic signed [63:0] x,
            logic signed [31:0] b0, logic signed [31:0] a1, logic signed [31:0] a2,
            inout logic signed [63:0] d0, inout logic signed [63:0] d1);
        logic signed [63:0] bx;
        logic signed [63:0] y;
        bx = scale_q30(x, b0);
        y  = clamp(bx + d0, 40);
        d0 = clamp(d1 - scale_q30(y, a1), 48);
        d1 = clamp(-bx - scale_q30(y, a2), 48);
        return y;
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            if (65'(c) * 65'(c) <= 65'(v))
                r = c;
        end
        return r;
    endfunction

    function automatic result_t predict_result(bit op, logic [17:0] raw);
        result_t            r;
        logic [63:0]        cnt;
        logic [63:0]        root;
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] f;
        logic [63:0]        sq;
        logic [64:0]        total;
        if (op == CMD_READ) begin
            r.fv = '0;
            r.dc = baseline;
            r.rms = '0;
            r.empty = 1'b1;
            if (sq_cnt != 0) begin
                root = 64'(floor_sqrt(sq_acc / 64'(sq_cnt)));
                r.rms = (root > 64'h3FF_FFFF) ? 26'h3FF_FFFF : root[25:0];
                r.empty = 1'b0;
            end
            sq_acc = '0;
            sq_cnt = '0;
            return r;
        end
        if (win_full) win_sum -= 64'(win_mem[win_pos]);
        win_mem[win_pos] = raw;
        win_sum += 64'(raw);
        win_pos++;
        if (win_pos >= WIN) begin
            win_pos = 0;
            win_full = 1'b1;
        end
        cnt = win_full ? 64'(WIN) : 64'(win_pos);
        baseline = 26'((win_sum << 8) / cnt);
        x = ($signed(64'(raw)) <<< 16) - ($signed(64'(baseline)) <<< 8);
        x = biquad_section(x, pdbr_pkg::S1_B0, pdbr_pkg::S1_A1, pdbr_pkg::S1_A2,
                           sec_dly[0], sec_dly[1]);
        x = biquad_section(x, pdbr_pkg::S2_B0, pdbr_pkg::S2_A1, pdbr_pkg::S2_A2,
                           sec_dly[2], sec_dly[3]);
        smooth_mem[smooth_pos] = x;
        smooth_pos = (smooth_pos + 1) % TAPS;
        s = 0;
        for (int i = 0; i < TAPS; i++) s += smooth_mem[i];
        s = s / TAPS;
        f = clamp((s + 64'sd128) >>> 8, 32);
        sq = 64'(f * f);
        total = 65'(sq_acc) + 65'(sq);
        sq_acc = total[64] ? '1 : total[63:0];
        if (sq_cnt != '1) sq_cnt++;
        r.fv = f[31:0];
        r.dc = baseline;
        r.rms = '0;
        r.empty = 1'b0;
        return r;
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_item(bit op, logic [17:0] raw, bit typed, result_t typed_res);
        result_t predicted;
        in_valid <= 1'b1;
        cmd <= op;
        raw_sample <= raw;
        do @(posedge clk); while (!(in_valid && !in_stall));
        predicted = predict_result(op, raw);
        if (typed && predicted != typed_res) begin
            $error("table row disagrees with predictor for cmd %0d raw %0d", op, raw);
            n_errors++;
        end
        pending_results.push_back(typed ? typed_res : predicted);
        if (op == CMD_READ) n_reads++; else n_samples++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // check results in order
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending");
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (filtered_value !== want.fv) begin
                    $error("filtered_value: expected %0d, got %0d", want.fv, filtered_value);
                    n_errors++;
                end
                if (dc_level !== want.dc) begin
                    $error("dc_level: expected %0d, got %0d", want.dc, dc_level);
                    n_errors++;
                end
                if (ac_rms !== want.rms) begin
                    $error("ac_rms: expected %0d, got %0d", want.rms, ac_rms);
                    n_errors++;
                end
                if (rms_empty !== want.empty) begin
                    $error("rms_empty: expected %0d, got %0d", want.empty, rms_empty);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall pattern, quiet stretches, one long hold-off
    initial begin
        int  cycle;
        int  mode;
        int  span;
        bit  held;
        cycle = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            if (!held && cycle > 4000) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                cycle += HOLD_LEN;
            end else begin
                repeat (span) begin
                    @(negedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 9) != 0);
                    endcase
                    cycle++;
                end
            end
        end
    end

    initial begin
        stim_row_t   table_rows[$];
        stim_row_t   row;
        result_t     none;
        result_t     empty_read;
        result_t     zero_sample;
        result_t     zero_read;
        int          burst;
        int          level;
        int          swing;
        logic [17:0] val;
        int          v;

        n_errors = 0; n_samples = 0; n_reads = 0; n_checked = 0; idle_cycles = 0;
        win_sum = '0; win_pos = 0; win_full = 1'b0; smooth_pos = 0;
        baseline = '0; sq_acc = '0; sq_cnt = '0;
        foreach (sec_dly[i]) sec_dly[i] = '0;
        foreach (smooth_mem[i]) smooth_mem[i] = '0;
        none = '{fv: 0, dc: 0, rms: 0, empty: 0};
        empty_read = '{fv: 0, dc: 0, rms: 0, empty: 1};
        zero_sample = '{fv: 0, dc: 0, rms: 0, empty: 0};
        zero_read = '{fv: 0, dc: 0, rms: 0, empty: 0};

        // reads on empty accumulators, a zero sample, then extremes and bit patterns
        table_rows.push_back('{CMD_READ, 18'd0, 1, empty_read});
        table_rows.push_back('{CMD_READ, 18'h3FFFF, 1, empty_read});
        table_rows.push_back('{CMD_SAMPLE, 18'd0, 1, zero_sample});
        table_rows.push_back('{CMD_READ, 18'd0, 1, zero_read});
        table_rows.push_back('{CMD_READ, 18'd0, 1, empty_read});
        table_rows.push_back('{CMD_SAMPLE, 18'h3FFFF, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h3FFFF, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'd0, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h2AAAA, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h15555, 0, none});
        table_rows.push_back('{CMD_READ, 18'h2AAAA, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h3FFFF, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'd0, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h3FFFF, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'd1, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h20000, 0, none});
        table_rows.push_back('{CMD_SAMPLE, 18'h1FFFF, 0, none});
        table_rows.push_back('{CMD_READ, 18'd0, 0, none});
        table_rows.push_back('{CMD_READ, 18'd0, 0, none});

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_rows[i]) begin
            row = table_rows[i];
            send_item(row.op, row.raw, row.typed, row.res);
            pause_sender($urandom_range(0, 2));
        end

        // random traffic: a baseline level that jumps at random, with a random swing,
        // occasional full-range samples, and reads every few dozen samples
        level = $urandom_range(0, 262143);
        swing = 2000;
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if ($urandom_range(0, 199) == 0) begin
                    level = $urandom_range(0, 262143);
                    swing = $urandom_range(0, 40000);
                end
                if ($urandom_range(0, 39) == 0) begin
                    send_item(CMD_READ, 18'($urandom), 0, none);
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        val = 18'($urandom);
                    end else begin
                        v = level + int'($urandom_range(0, 2 * swing)) - swing;
                        if (v < 0) v = 0;
                        if (v > 262143) v = 262143;
                        val = 18'(v);
                    end
                    send_item(CMD_SAMPLE, val, 0, none);
                end
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(0, 30));
        end
        send_item(CMD_READ, 18'd0, 0, none);
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (300) @(posedge clk);

        $display("covered %0d samples and %0d reads, %0d results compared",
                 n_samples, n_reads, n_checked);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
